// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition never occurs.
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

// File: design/lbpce_pkg.sv
// ----------------------------------------------------------------------------
// lbpce_pkg
// Shared constants and types of the LED bit PWM chunk encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpce_pkg;

   localparam int CHUNK     = 24;
   localparam int POS_W     = $clog2(CHUNK);
   localparam int PAD_W     = $clog2(CHUNK + 1);
   localparam int DUTY_W    = 8;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = $clog2(BYTE_W);
   localparam int QDEPTH    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0]  LAST_BIT      = CNT_W'(BYTE_W - 1);
   localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 8'd47;
   localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 8'd26;
   localparam logic [DUTY_W-1:0] PAD_DUTY      = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ONE_DUTY  = 2'd0,
      REG_ZERO_DUTY = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] color_byte;
      logic              last_byte;
      logic [PAD_W-1:0]  pad;
   } entry_type;

endpackage

`default_nettype wire

// File: design/led_bit_pwm_chunk_encoder.sv
// ----------------------------------------------------------------------------
// led_bit_pwm_chunk_encoder
// Turns LED color bytes into PWM compare values, one slot per bit, and pads
// each frame with zero slots up to the end of the current chunk.
//
//   Port group  Direction  Handshake               Payload
//   req_        in         req_push / req_full     color_byte, last_byte
//   rsp_        out        rsp_pop / rsp_empty     duty, last_of_item, frame_done
//   csr_        in         csr_valid / csr_ready   index, wdata
//
// The back-end serializer expands a byte into 8 slots, one slot per cycle
// while the result is taken; a frame's last byte adds its padding, 1 to CHUNK slots.
// The front accepts the next byte into a two-entry queue while the back works.
// Reset is synchronous; no clearing pass follows.
// A held result stalls the serializer; a full queue raises req_full.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bit_pwm_chunk_encoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [lbpce_pkg::BYTE_W-1:0]    req_color_byte,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [lbpce_pkg::DUTY_W-1:0]         rsp_duty,
   output logic                                 rsp_last_of_item,
   output logic                                 rsp_frame_done,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lbpce_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lbpce_pkg::DUTY_W-1:0]    csr_wdata
);

   logic [lbpce_pkg::DUTY_W-1:0] one_duty_ff, one_duty_in;
   logic [lbpce_pkg::DUTY_W-1:0] zero_duty_ff, zero_duty_in;
   logic                         q_push;
   logic                         q_ready;
   logic                         q_valid;
   logic                         q_pop;
   lbpce_pkg::entry_type         q_entry;
   lbpce_pkg::entry_type         q_head;

   always_comb begin
      csr_ready    = 1'b1;
      one_duty_in  = one_duty_ff;
      zero_duty_in = zero_duty_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lbpce_pkg::REG_ONE_DUTY:  one_duty_in  = csr_wdata;
            lbpce_pkg::REG_ZERO_DUTY: zero_duty_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= lbpce_pkg::ONE_DUTY_RST;
         zero_duty_ff <= lbpce_pkg::ZERO_DUTY_RST;
      end else begin
         one_duty_ff  <= one_duty_in;
         zero_duty_ff <= zero_duty_in;
      end
   end

   lbpce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_color_byte (req_color_byte),
      .req_last_byte  (req_last_byte),
      .q_ready        (q_ready),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   lbpce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .ready      (q_ready),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   lbpce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .one_duty         (one_duty_ff),
      .zero_duty        (zero_duty_ff),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_duty         (rsp_duty),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

`default_nettype wire

// File: design/lbpce_front.sv
// ----------------------------------------------------------------------------
// lbpce_front
// Accepts color bytes, tracks the chunk position and works out the padding
// count that a frame's last byte needs.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpce_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic [lbpce_pkg::BYTE_W-1:0] req_color_byte,
   input  wire logic                         req_last_byte,
   input  wire logic                         q_ready,
   output logic                              q_push,
   output lbpce_pkg::entry_type              q_entry
);

   logic [lbpce_pkg::POS_W-1:0] pos_ff;
   logic [lbpce_pkg::POS_W-1:0] pos_in;
   logic [lbpce_pkg::POS_W:0]   sum;
   logic [lbpce_pkg::POS_W-1:0] wrapped;

   always_comb begin
      req_full = !q_ready;
      q_push   = req_push && q_ready;
      sum      = {1'b0, pos_ff} + (lbpce_pkg::POS_W + 1)'(lbpce_pkg::BYTE_W);
      if (sum >= (lbpce_pkg::POS_W + 1)'(lbpce_pkg::CHUNK)) begin
         wrapped = lbpce_pkg::POS_W'(sum - (lbpce_pkg::POS_W + 1)'(lbpce_pkg::CHUNK));
      end else begin
         wrapped = lbpce_pkg::POS_W'(sum);
      end
      q_entry.color_byte = req_color_byte;
      q_entry.last_byte  = req_last_byte;
      q_entry.pad        = lbpce_pkg::PAD_W'(lbpce_pkg::CHUNK)
                         - lbpce_pkg::PAD_W'(wrapped);
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = req_last_byte ? '0 : wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lbpce_queue.sv
// ----------------------------------------------------------------------------
// lbpce_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lbpce_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lbpce_pkg::entry_type  push_entry,
   output logic                       ready,
   input  wire logic                  pop,
   output logic                       valid,
   output lbpce_pkg::entry_type       head
);

   localparam int PTR_W = (lbpce_pkg::QDEPTH > 1) ? $clog2(lbpce_pkg::QDEPTH) : 1;
   localparam int CNT_W = $clog2(lbpce_pkg::QDEPTH + 1);

   lbpce_pkg::entry_type entry_ff [lbpce_pkg::QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      ready   = count_ff != CNT_W'(lbpce_pkg::QDEPTH);
      valid   = count_ff != '0;
      head    = entry_ff[rd_ptr_ff];
      do_push = push && ready;
      do_pop  = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lbpce_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lbpce_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_q_overflow, push && !ready, "item pushed into a full queue")
   `ASSERT_CLK(a_q_count, count_ff <= CNT_W'(lbpce_pkg::QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

// File: design/lbpce_back.sv
// ----------------------------------------------------------------------------
// lbpce_back
// Serializes each queued byte MSB first into duty slots, appends the frame
// padding and holds the current result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lbpce_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [lbpce_pkg::DUTY_W-1:0] one_duty,
   input  wire logic [lbpce_pkg::DUTY_W-1:0] zero_duty,
   input  wire logic                         q_valid,
   input  wire lbpce_pkg::entry_type         q_head,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic [lbpce_pkg::DUTY_W-1:0]      rsp_duty,
   output logic                              rsp_last_of_item,
   output logic                              rsp_frame_done
);

   logic                              busy_ff, busy_in;
   logic                              padding_ff, padding_in;
   logic                              last_ff, last_in;
   logic [lbpce_pkg::BYTE_W-1:0]      shift_ff, shift_in;
   logic [lbpce_pkg::CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [lbpce_pkg::PAD_W-1:0]       pad_left_ff, pad_left_in;
   logic                              out_valid_ff, out_valid_in;
   logic [lbpce_pkg::DUTY_W-1:0]      out_duty_ff, out_duty_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_done_ff, out_done_in;
   logic                              adv;
   logic                              fire;
   logic                              final_slot;
   logic                              load;
   logic [lbpce_pkg::DUTY_W-1:0]      slot_duty;

   always_comb begin
      adv = !out_valid_ff || rsp_pop;
      fire = busy_ff && adv;
      if (padding_ff) begin
         final_slot = pad_left_ff == lbpce_pkg::PAD_W'(1);
         slot_duty  = lbpce_pkg::PAD_DUTY;
      end else begin
         final_slot = (bit_cnt_ff == lbpce_pkg::LAST_BIT) && !last_ff;
         slot_duty  = shift_ff[lbpce_pkg::BYTE_W-1] ? one_duty : zero_duty;
      end
      load  = q_valid && (!busy_ff || (fire && final_slot));
      q_pop = load;

      busy_in     = busy_ff;
      padding_in  = padding_ff;
      last_in     = last_ff;
      shift_in    = shift_ff;
      bit_cnt_in  = bit_cnt_ff;
      pad_left_in = pad_left_ff;
      if (fire) begin
         if (padding_ff) begin
            pad_left_in = pad_left_ff - 1'b1;
         end else begin
            shift_in   = shift_ff << 1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == lbpce_pkg::LAST_BIT && last_ff) begin
               padding_in = 1'b1;
            end
         end
         if (final_slot) begin
            busy_in    = 1'b0;
            padding_in = 1'b0;
         end
      end
      if (load) begin
         busy_in     = 1'b1;
         padding_in  = 1'b0;
         last_in     = q_head.last_byte;
         shift_in    = q_head.color_byte;
         bit_cnt_in  = '0;
         pad_left_in = q_head.pad;
      end

      out_valid_in = out_valid_ff;
      out_duty_in  = out_duty_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (adv) begin
         out_valid_in = busy_ff;
      end
      if (fire) begin
         out_duty_in = slot_duty;
         out_last_in = final_slot;
         out_done_in = padding_ff && final_slot;
      end

      rsp_empty        = !out_valid_ff;
      rsp_duty         = out_duty_ff;
      rsp_last_of_item = out_last_ff;
      rsp_frame_done   = out_done_ff;
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      shift_ff    <= shift_in;
      bit_cnt_ff  <= bit_cnt_in;
      pad_left_ff <= pad_left_in;
      out_duty_ff <= out_duty_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         padding_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         padding_ff   <= padding_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `ASSERT_NEVER(a_pad_state, padding_ff && (!busy_ff || !last_ff || pad_left_ff == '0),
      "padding without a pending frame end")
   `ASSERT_CLK(a_done_last, (out_valid_ff && out_done_ff) |-> out_last_ff,
      "frame_done without last_of_item")

endmodule

`default_nettype wire

// File: verif/tb_led_bit_pwm_chunk_encoder.sv
// ----------------------------------------------------------------------------
// tb_led_bit_pwm_chunk_encoder
// Streams LED color bytes, grouped into frames, through the encoder with
// random gaps on both queue sides. Each accepted byte is expanded locally
// into its expected duty slots and frame padding, and every popped slot is
// checked in order. Duty registers are reprogrammed between drained phases,
// including both extremes and writes to unused register indexes.
// ----------------------------------------------------------------------------
module tb_led_bit_pwm_chunk_encoder;

   localparam logic [lbpce_pkg::CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [lbpce_pkg::CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [lbpce_pkg::DUTY_W-1:0] duty;
      logic                         last_of_item;
      logic                         frame_done;
   } slot_type;

   class pwm_slot_scoreboard;
      slot_type                     pending_slots[$];
      logic [lbpce_pkg::DUTY_W-1:0] one_duty;
      logic [lbpce_pkg::DUTY_W-1:0] zero_duty;
      int unsigned                  slot_pos;
      int unsigned                  mismatches;

      function new();
         one_duty   = lbpce_pkg::ONE_DUTY_RST;
         zero_duty  = lbpce_pkg::ZERO_DUTY_RST;
         slot_pos   = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [lbpce_pkg::CSR_IDX_W-1:0] idx,
                              logic [lbpce_pkg::DUTY_W-1:0] value);
         case (idx)
            lbpce_pkg::REG_ONE_DUTY: begin
               one_duty = value;
            end
            lbpce_pkg::REG_ZERO_DUTY: begin
               zero_duty = value;
            end
            default: begin
            end
         endcase
      endfunction

      // expand one byte into its bit slots, then pad the chunk on a frame end
      function void note_byte(logic [lbpce_pkg::BYTE_W-1:0] color, logic last);
         slot_type    s;
         int unsigned pad;
         for (int b = lbpce_pkg::BYTE_W - 1; b >= 0; b--) begin
            s.duty         = color[b] ? one_duty : zero_duty;
            s.last_of_item = !last && (b == 0);
            s.frame_done   = 1'b0;
            pending_slots.push_back(s);
            slot_pos = (slot_pos + 1) % lbpce_pkg::CHUNK;
         end
         if (last) begin
            pad = lbpce_pkg::CHUNK - slot_pos;
            for (int p = 1; p <= pad; p++) begin
               s.duty         = lbpce_pkg::PAD_DUTY;
               s.last_of_item = (p == pad);
               s.frame_done   = (p == pad);
               pending_slots.push_back(s);
            end
            slot_pos = 0;
         end
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_slot(input slot_type got);
         slot_type want;
         if (pending_slots.size() == 0) begin
            report_mismatch($sformatf("unexpected slot duty=%0d last=%0b done=%0b",
                                      got.duty, got.last_of_item, got.frame_done));
         end else begin
            want = pending_slots.pop_front();
            if (got.duty !== want.duty)
               report_mismatch($sformatf("duty got %0d want %0d", got.duty, want.duty));
            if (got.last_of_item !== want.last_of_item)
               report_mismatch($sformatf("last_of_item got %0b want %0b",
                                         got.last_of_item, want.last_of_item));
            if (got.frame_done !== want.frame_done)
               report_mismatch($sformatf("frame_done got %0b want %0b",
                                         got.frame_done, want.frame_done));
         end
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_push;
   logic                                req_full;
   logic [lbpce_pkg::BYTE_W-1:0]        req_color_byte;
   logic                                req_last_byte;
   logic                                rsp_empty;
   logic                                rsp_pop;
   logic [lbpce_pkg::DUTY_W-1:0]        rsp_duty;
   logic                                rsp_last_of_item;
   logic                                rsp_frame_done;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [lbpce_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [lbpce_pkg::DUTY_W-1:0]        csr_wdata;

   pwm_slot_scoreboard sb;
   bit                 calm;

   led_bit_pwm_chunk_encoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_color_byte   (req_color_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_duty         (rsp_duty),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned pick_frame_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25)
         return 3 * $urandom_range(1, 3);
      if (r < 85)
         return $urandom_range(1, 6);
      return $urandom_range(7, 14);
   endfunction

   // result side: pop with random stalls
   initial begin
      int unsigned stall;
      slot_type    got;
      stall   = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.duty         = rsp_duty;
            got.last_of_item = rsp_last_of_item;
            got.frame_done   = rsp_frame_done;
            sb.check_slot(got);
            stall = pick_gap();
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [lbpce_pkg::BYTE_W-1:0] color, input logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_color_byte <= color;
      req_last_byte  <= last;
      do @(posedge clock); while (req_full);
      sb.note_byte(color, last);
   endtask

   task automatic send_frames(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         len = pick_frame_len();
         for (int i = 1; i <= len; i++)
            send_byte(8'($urandom), i == len);
         sent += len;
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending_slots.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [lbpce_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lbpce_pkg::DUTY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
   endtask

   task automatic program_duties(input logic [lbpce_pkg::DUTY_W-1:0] one,
                                 input logic [lbpce_pkg::DUTY_W-1:0] zero,
                                 input logic [lbpce_pkg::CSR_IDX_W-1:0] spare);
      write_csr(lbpce_pkg::REG_ONE_DUTY, one);
      write_csr(spare, 8'($urandom));
      write_csr(lbpce_pkg::REG_ZERO_DUTY, zero);
      csr_valid <= 1'b0;
   endtask

   initial begin
      sb             = new();
      calm           = 1'b0;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_color_byte = '0;
      req_last_byte  = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // frame ending on a chunk boundary
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      // single-byte frame, ends inside a chunk
      send_byte(8'h01, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
      // two full chunks of data, then a whole padding chunk
      for (int i = 1; i <= 6; i++)
         send_byte(8'($urandom), i == 6);
      for (int i = 1; i <= 5; i++)
         send_byte(8'($urandom), i == 5);

      wait_drained();
      program_duties(8'hFF, 8'h00, REG_SPARE_2);
      send_frames(25);

      wait_drained();
      program_duties(8'h00, 8'hFF, REG_SPARE_3);
      calm = 1'b1;
      send_frames(25);
      calm = 1'b0;

      wait_drained();
      program_duties(8'h00, 8'h00, REG_SPARE_2);
      send_frames(15);

      wait_drained();
      program_duties(8'hFF, 8'hFF, REG_SPARE_3);
      send_frames(15);

      wait_drained();
      program_duties(8'($urandom), 8'($urandom), REG_SPARE_2);
      send_frames(20);

      wait_drained();
      program_duties(lbpce_pkg::ONE_DUTY_RST, lbpce_pkg::ZERO_DUTY_RST, REG_SPARE_3);
      send_frames(15);

      wait_drained();
      repeat (2 * (lbpce_pkg::BYTE_W + lbpce_pkg::CHUNK)) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_slots.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
